[design/lpg_pkg.sv]
`default_nettype none

package lpg_pkg;

   // Field widths of the request and response transactions.
   localparam int unsigned X_W    = 10;
   localparam int unsigned Y_W    = 9;
   localparam int unsigned ADDR_W = 19;
   localparam int unsigned COL_W  = 12;

   // Internal widths: positions along either axis and the signed error term.
   localparam int unsigned POS_W = 10;
   localparam int unsigned ERR_W = 11;

   // Request operation codes.
   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } opcode_type;

endpackage

`default_nettype wire

[design/line_pixel_generator_core.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  opcode, endpoints, colour
// rsp_      out        rsp_valid/rsp_ready  pixel x/y, address, colour, last flag
//
// One request transaction is taken per clock. A step that yields a pixel shows it on
// rsp_ in the cycle after acceptance, from the response register.
// The throughput is set by the single response register: req_ready is high whenever
// that register is empty or is being emptied in the same cycle.
// A synchronous reset clears the line state and the response valid flag.
// While a response is stalled no request is taken.

module line_pixel_generator_core #(
   parameter int unsigned SCREEN_WIDTH = 640,
   parameter int unsigned COLOR_BITS   = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [lpg_pkg::X_W-1:0]     req_x_start,
   input  logic [lpg_pkg::Y_W-1:0]     req_y_start,
   input  logic [lpg_pkg::X_W-1:0]     req_x_end,
   input  logic [lpg_pkg::Y_W-1:0]     req_y_end,
   input  logic [lpg_pkg::COL_W-1:0]   req_color,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lpg_pkg::X_W-1:0]     rsp_pixel_x,
   output logic [lpg_pkg::Y_W-1:0]     rsp_pixel_y,
   output logic [lpg_pkg::ADDR_W-1:0]  rsp_pixel_address,
   output logic [lpg_pkg::COL_W-1:0]   rsp_pixel_color,
   output logic                        rsp_last_pixel
);
   import lpg_pkg::*;

   // Stored colour keeps only the bits that survive both masks.
   localparam int unsigned LCOL_W = (COLOR_BITS < COL_W) ? COLOR_BITS : COL_W;
   // Address arithmetic width: wide enough for row * width + column, and for the field.
   localparam int unsigned SW_W    = $clog2(SCREEN_WIDTH + 1);
   localparam int unsigned PROD_W  = Y_W + SW_W + 1;
   localparam int unsigned AFULL_W = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;
   localparam logic [AFULL_W-1:0] WIDTH_K = AFULL_W'(SCREEN_WIDTH);

   // Line state.
   logic              busy_ff, busy_in;
   logic              steep_ff, steep_in;
   logic [POS_W-1:0]  major_pos_ff, major_pos_in;
   logic [POS_W-1:0]  minor_pos_ff, minor_pos_in;
   logic [POS_W-1:0]  major_end_ff, major_end_in;
   logic [POS_W-1:0]  run_dx_ff, run_dx_in;
   logic [POS_W-1:0]  run_dy_ff, run_dy_in;
   logic [ERR_W-1:0]  error_ff, error_in;
   logic              minor_down_ff, minor_down_in;
   logic [LCOL_W-1:0] line_color_ff, line_color_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [X_W-1:0]    rsp_x_ff, rsp_x_in;
   logic [Y_W-1:0]    rsp_y_ff, rsp_y_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [COL_W-1:0]  rsp_color_ff, rsp_color_in;
   logic              rsp_last_ff, rsp_last_in;

   // Setup path signals.
   logic [POS_W-1:0]  x0, y0, x1, y1, dx_abs, dy_abs;
   logic [POS_W-1:0]  a0, b0, a1, b1;
   logic [POS_W-1:0]  lo_major, lo_minor, hi_major, hi_minor;
   logic              steep_new, swap_ends;

   // Step path signals.
   logic              req_fire, is_start, emit;
   logic [POS_W-1:0]  px, py;
   logic              last;
   logic [AFULL_W-1:0] addr_full;
   logic [ERR_W:0]    err_sub, err_next;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_start  = (req_opcode == OP_START);
   assign emit      = req_fire && !is_start && busy_ff;

   // Start: pick the major axis and order the endpoints along it.
   always_comb begin
      x0 = POS_W'(req_x_start);
      y0 = POS_W'(req_y_start);
      x1 = POS_W'(req_x_end);
      y1 = POS_W'(req_y_end);
      dx_abs = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
      dy_abs = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
      steep_new = dy_abs > dx_abs;
      a0 = steep_new ? y0 : x0;
      b0 = steep_new ? x0 : y0;
      a1 = steep_new ? y1 : x1;
      b1 = steep_new ? x1 : y1;
      swap_ends = a0 > a1;
      lo_major  = swap_ends ? a1 : a0;
      lo_minor  = swap_ends ? b1 : b0;
      hi_major  = swap_ends ? a0 : a1;
      hi_minor  = swap_ends ? b0 : b1;
   end

   // Step: current pixel, its address and the error update.
   always_comb begin
      px = steep_ff ? minor_pos_ff : major_pos_ff;
      py = steep_ff ? major_pos_ff : minor_pos_ff;
      last = (major_pos_ff == major_end_ff);
      addr_full = AFULL_W'(py[Y_W-1:0]) * WIDTH_K + AFULL_W'(px);
      err_sub = {error_ff[ERR_W-1], error_ff} - {2'b00, run_dy_ff};
      err_next = err_sub[ERR_W] ? (err_sub + {2'b00, run_dx_ff}) : err_sub;
   end

   // Next line state.
   always_comb begin
      busy_in       = busy_ff;
      steep_in      = steep_ff;
      major_pos_in  = major_pos_ff;
      minor_pos_in  = minor_pos_ff;
      major_end_in  = major_end_ff;
      run_dx_in     = run_dx_ff;
      run_dy_in     = run_dy_ff;
      error_in      = error_ff;
      minor_down_in = minor_down_ff;
      line_color_in = line_color_ff;
      if (req_fire && is_start) begin
         busy_in       = 1'b1;
         steep_in      = steep_new;
         major_pos_in  = lo_major;
         minor_pos_in  = lo_minor;
         major_end_in  = hi_major;
         run_dx_in     = hi_major - lo_major;
         run_dy_in     = (hi_minor >= lo_minor) ? (hi_minor - lo_minor)
                                                : (lo_minor - hi_minor);
         error_in      = ERR_W'((hi_major - lo_major) >> 1);
         minor_down_in = !(lo_minor < hi_minor);
         line_color_in = req_color[LCOL_W-1:0];
      end else if (emit) begin
         busy_in      = !last;
         major_pos_in = major_pos_ff + 1'b1;
         error_in     = err_next[ERR_W-1:0];
         if (err_sub[ERR_W]) begin
            minor_pos_in = minor_down_ff ? (minor_pos_ff - 1'b1) : (minor_pos_ff + 1'b1);
         end
      end
   end

   // Next response register contents.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = px[X_W-1:0];
         rsp_y_in     = py[Y_W-1:0];
         rsp_addr_in  = addr_full[ADDR_W-1:0];
         rsp_color_in = COL_W'(line_color_ff);
         rsp_last_in  = last;
      end
   end

   // Control state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         steep_ff      <= 1'b0;
         major_pos_ff  <= '0;
         minor_pos_ff  <= '0;
         major_end_ff  <= '0;
         run_dx_ff     <= '0;
         run_dy_ff     <= '0;
         error_ff      <= '0;
         minor_down_ff <= 1'b0;
         line_color_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         steep_ff      <= steep_in;
         major_pos_ff  <= major_pos_in;
         minor_pos_ff  <= minor_pos_in;
         major_end_ff  <= major_end_in;
         run_dx_ff     <= run_dx_in;
         run_dy_ff     <= run_dy_in;
         error_ff      <= error_in;
         minor_down_ff <= minor_down_in;
         line_color_ff <= line_color_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Response payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_x       = rsp_x_ff;
   assign rsp_pixel_y       = rsp_y_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_pixel_color   = rsp_color_ff;
   assign rsp_last_pixel    = rsp_last_ff;

endmodule

`default_nettype wire

[design/lpg_checker.sv]
`default_nettype none

module lpg_checker #(
   parameter int unsigned SCREEN_WIDTH = 640
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_opcode,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [lpg_pkg::X_W-1:0]     rsp_pixel_x,
   input logic [lpg_pkg::Y_W-1:0]     rsp_pixel_y,
   input logic [lpg_pkg::ADDR_W-1:0]  rsp_pixel_address,
   input logic [lpg_pkg::COL_W-1:0]   rsp_pixel_color,
   input logic                        rsp_last_pixel
);
   import lpg_pkg::*;

   logic req_fire, start_fire, step_fire, rsp_fire, rsp_stall;
   logic [31:0] addr_expect;

   assign req_fire    = req_valid && req_ready;
   assign start_fire  = req_fire && (req_opcode == OP_START);
   assign step_fire   = req_fire && (req_opcode == OP_STEP);
   assign rsp_fire    = rsp_valid && rsp_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign addr_expect = 32'(rsp_pixel_y) * 32'(SCREEN_WIDTH) + 32'(rsp_pixel_x);

   // A stalled response transaction keeps its whole payload.
   stalled_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_stall |=> rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
                    && $stable(rsp_pixel_address) && $stable(rsp_pixel_color)
                    && $stable(rsp_last_pixel))
      else $error("stalled response changed");

   // No request is taken while a response waits, so none can be lost.
   no_accept_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_stall |-> !req_ready)
      else $error("request accepted while response stalled");

   // A start never yields a pixel.
   start_gives_nothing: assert property (@(posedge clock) disable iff (reset)
      (start_fire && !rsp_stall) |=> !rsp_valid)
      else $error("start produced a response");

   // Once the final pixel has gone, a step without a new start gives nothing.
   idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_pixel && !start_fire) ##1 step_fire |=> !rsp_valid)
      else $error("pixel produced after end of line");

   // The address agrees with the coordinates shown beside it.
   address_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_address == addr_expect[ADDR_W-1:0])
      else $error("pixel address does not match coordinates");

endmodule

bind line_pixel_generator_core lpg_checker #(
   .SCREEN_WIDTH (SCREEN_WIDTH)
) u_lpg_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_opcode        (req_opcode),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_pixel_x       (rsp_pixel_x),
   .rsp_pixel_y       (rsp_pixel_y),
   .rsp_pixel_address (rsp_pixel_address),
   .rsp_pixel_color   (rsp_pixel_color),
   .rsp_last_pixel    (rsp_last_pixel)
);

`default_nettype wire

[verif/line_pixel_generator_core_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the line pixel generator. It keeps its own copy of the
// rasteriser state, predicts each pixel and checks every response transaction.
module line_pixel_generator_core_checker #(
   parameter int unsigned SCREEN_WIDTH = 640
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [lpg_pkg::X_W-1:0]     req_x_start,
   input  logic [lpg_pkg::Y_W-1:0]     req_y_start,
   input  logic [lpg_pkg::X_W-1:0]     req_x_end,
   input  logic [lpg_pkg::Y_W-1:0]     req_y_end,
   input  logic [lpg_pkg::COL_W-1:0]   req_color,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [lpg_pkg::X_W-1:0]     rsp_pixel_x,
   input  logic [lpg_pkg::Y_W-1:0]     rsp_pixel_y,
   input  logic [lpg_pkg::ADDR_W-1:0]  rsp_pixel_address,
   input  logic [lpg_pkg::COL_W-1:0]   rsp_pixel_color,
   input  logic                        rsp_last_pixel,
   output int                          fail_count,
   output int                          pending_pixels,
   output int                          lines_started,
   output int                          pixels_checked
);

   localparam int POS_MASK  = (1 << lpg_pkg::POS_W) - 1;
   localparam int ADDR_MASK = (1 << lpg_pkg::ADDR_W) - 1;

   typedef struct {
      logic [lpg_pkg::X_W-1:0]    x;
      logic [lpg_pkg::Y_W-1:0]    y;
      logic [lpg_pkg::ADDR_W-1:0] addr;
      logic [lpg_pkg::COL_W-1:0]  colour;
      logic                       last;
   } pixel_type;

   pixel_type pixel_q[$];

   // Rasteriser state as the block should hold it.
   bit                         line_busy;
   bit                         line_steep;
   int                         major_at;
   int                         minor_at;
   int                         major_stop;
   int                         span_major;
   int                         span_minor;
   int                         err_acc;
   bit                         minor_dec;
   logic [lpg_pkg::COL_W-1:0]  line_colour;

   int mismatch_total;
   int line_total;
   int pixel_total;

   function automatic int distance(int a, int b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic int check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // A start swaps the axes of a steep line and orders the ends so that the major
   // coordinate rises; the error term begins at half the major span.
   task automatic latch_line(input int x0, input int y0, input int x1, input int y1,
                             input logic [lpg_pkg::COL_W-1:0] colour);
      int a0, b0, a1, b1, t;
      line_steep = distance(y1, y0) > distance(x1, x0);
      if (line_steep) begin
         a0 = y0; b0 = x0; a1 = y1; b1 = x1;
      end else begin
         a0 = x0; b0 = y0; a1 = x1; b1 = y1;
      end
      if (a0 > a1) begin
         t = a0; a0 = a1; a1 = t;
         t = b0; b0 = b1; b1 = t;
      end
      major_at    = a0 & POS_MASK;
      minor_at    = b0 & POS_MASK;
      major_stop  = a1 & POS_MASK;
      span_major  = (a1 - a0) & POS_MASK;
      span_minor  = distance(b1, b0) & POS_MASK;
      err_acc     = span_major / 2;
      minor_dec   = !(b0 < b1);
      line_colour = colour;
      line_busy   = 1'b1;
   endtask

   // Emits the current pixel and moves one step along the major axis.
   task automatic advance_pixel(output pixel_type pix);
      int px, py;
      px       = line_steep ? minor_at : major_at;
      py       = line_steep ? major_at : minor_at;
      pix.x    = lpg_pkg::X_W'(px);
      pix.y    = lpg_pkg::Y_W'(py);
      pix.addr = lpg_pkg::ADDR_W'((py * SCREEN_WIDTH + px) & ADDR_MASK);
      pix.colour = line_colour;
      pix.last = (major_at == major_stop);
      err_acc -= span_minor;
      if (err_acc < 0) begin
         minor_at = (minor_dec ? minor_at - 1 : minor_at + 1) & POS_MASK;
         err_acc += span_major;
      end
      major_at = (major_at + 1) & POS_MASK;
      if (pix.last) line_busy = 1'b0;
   endtask

   // The response is checked before the request of the same edge is predicted,
   // since a pixel is registered and always leaves after its step.
   always @(posedge clock) begin : monitor
      pixel_type want;
      if (reset) begin
         pixel_q.delete();
         line_busy  = 1'b0;
         line_steep = 1'b0;
         major_at   = 0;
         minor_at   = 0;
         major_stop = 0;
         span_major = 0;
         span_minor = 0;
         err_acc    = 0;
         minor_dec  = 1'b0;
         line_colour = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               $error("pixel (%0d,%0d) arrived with none expected", rsp_pixel_x, rsp_pixel_y);
               mismatch_total++;
            end else begin
               want = pixel_q.pop_front();
               mismatch_total += check_field("pixel_x", int'(want.x), int'(rsp_pixel_x));
               mismatch_total += check_field("pixel_y", int'(want.y), int'(rsp_pixel_y));
               mismatch_total += check_field("pixel_address", int'(want.addr),
                                             int'(rsp_pixel_address));
               mismatch_total += check_field("pixel_color", int'(want.colour),
                                             int'(rsp_pixel_color));
               mismatch_total += check_field("last_pixel", int'(want.last),
                                             int'(rsp_last_pixel));
               pixel_total++;
            end
         end
         if (req_valid && req_ready) begin
            if (req_opcode == lpg_pkg::OP_START) begin
               latch_line(int'(req_x_start), int'(req_y_start), int'(req_x_end),
                          int'(req_y_end), req_color);
               line_total++;
            end else if (line_busy) begin
               advance_pixel(want);
               pixel_q.push_back(want);
            end
         end
      end
      fail_count     <= mismatch_total;
      pending_pixels <= pixel_q.size();
      lines_started  <= line_total;
      pixels_checked <= pixel_total;
   end

endmodule

[verif/line_pixel_generator_core_tb.sv]
`timescale 1ns / 100ps

module line_pixel_generator_core_tb;

   localparam int SCREEN_W    = 640;
   localparam int X_MAX       = 639;
   localparam int Y_MAX       = 479;
   localparam int ITEM_TARGET = 1000;
   localparam int PAUSE_EVERY = 250;
   localparam int TAIL_CYCLES = 10;
   localparam int STALL_LIMIT = 2000;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_opcode;
   logic [lpg_pkg::X_W-1:0]     req_x_start;
   logic [lpg_pkg::Y_W-1:0]     req_y_start;
   logic [lpg_pkg::X_W-1:0]     req_x_end;
   logic [lpg_pkg::Y_W-1:0]     req_y_end;
   logic [lpg_pkg::COL_W-1:0]   req_color;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [lpg_pkg::X_W-1:0]     rsp_pixel_x;
   logic [lpg_pkg::Y_W-1:0]     rsp_pixel_y;
   logic [lpg_pkg::ADDR_W-1:0]  rsp_pixel_address;
   logic [lpg_pkg::COL_W-1:0]   rsp_pixel_color;
   logic                        rsp_last_pixel;

   int fail_count;
   int pending_pixels;
   int lines_started;
   int pixels_checked;
   int items_sent;
   int stall_left;
   int idle_cycles;
   bit steady;

   line_pixel_generator_core #(
      .SCREEN_WIDTH (SCREEN_W),
      .COLOR_BITS   (lpg_pkg::COL_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_x_start       (req_x_start),
      .req_y_start       (req_y_start),
      .req_x_end         (req_x_end),
      .req_y_end         (req_y_end),
      .req_color         (req_color),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_pixel    (rsp_last_pixel)
   );

   line_pixel_generator_core_checker #(
      .SCREEN_WIDTH (SCREEN_W)
   ) checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_x_start       (req_x_start),
      .req_y_start       (req_y_start),
      .req_x_end         (req_x_end),
      .req_y_end         (req_y_end),
      .req_color         (req_color),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_pixel    (rsp_last_pixel),
      .fail_count        (fail_count),
      .pending_pixels    (pending_pixels),
      .lines_started     (lines_started),
      .pixels_checked    (pixels_checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Response side: mostly ready, with short stalls and now and then a long one.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 99) < 20) begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: ends the run if neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("** line_pixel_generator_core: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int clamp(int v, int hi);
      return (v < 0) ? 0 : (v > hi) ? hi : v;
   endfunction

   // Presents one request transaction after a random gap and holds it until taken.
   task automatic send_req(input lpg_pkg::opcode_type op,
                           input logic [lpg_pkg::X_W-1:0] x0, input logic [lpg_pkg::Y_W-1:0] y0,
                           input logic [lpg_pkg::X_W-1:0] x1, input logic [lpg_pkg::Y_W-1:0] y1,
                           input logic [lpg_pkg::COL_W-1:0] colour);
      int gap, roll;
      roll = $urandom_range(0, 99);
      gap  = steady ? 0 : (roll < 60) ? 0 : (roll < 92) ? $urandom_range(1, 3)
                                                        : $urandom_range(10, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_x_start <= x0;
      req_y_start <= y0;
      req_x_end   <= x1;
      req_y_end   <= y1;
      req_color   <= colour;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Step transactions carry random endpoint fields, which the block must ignore.
   task automatic send_step();
      send_req(lpg_pkg::OP_STEP,
               lpg_pkg::X_W'($urandom_range(0, X_MAX)), lpg_pkg::Y_W'($urandom_range(0, Y_MAX)),
               lpg_pkg::X_W'($urandom_range(0, X_MAX)), lpg_pkg::Y_W'($urandom_range(0, Y_MAX)),
               lpg_pkg::COL_W'($urandom_range(0, 4095)));
   endtask

   task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                            input int colour, input int steps);
      send_req(lpg_pkg::OP_START, lpg_pkg::X_W'(x0), lpg_pkg::Y_W'(y0),
               lpg_pkg::X_W'(x1), lpg_pkg::Y_W'(y1), lpg_pkg::COL_W'(colour));
      repeat (steps) send_step();
   endtask

   // Holds the sender off until every predicted pixel has been delivered.
   task automatic drain_pixels();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels != 0) @(posedge clock);
   endtask

   initial begin
      int kind, reach, fate, steps, next_pause;
      int x0, y0, x1, y1;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_opcode  = lpg_pkg::OP_START;
      req_x_start = '0;
      req_y_start = '0;
      req_x_end   = '0;
      req_y_end   = '0;
      req_color   = '0;
      rsp_ready   = 1'b1;
      stall_left  = 0;
      idle_cycles = 0;
      items_sent  = 0;
      steady      = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: a step with no line, single-point lines at both screen corners,
      // a shallow line drawn right to left, a steep line, and a line abandoned midway.
      send_step();
      draw_line(0, 0, 0, 0, 0, 2);
      draw_line(X_MAX, Y_MAX, X_MAX, Y_MAX, 4095, 1);
      draw_line(X_MAX, 0, X_MAX - 3, 3, 12'h5A5, 4);
      draw_line(10, 100, 12, 105, 12'hA5A, 6);
      draw_line(100, 200, 300, 200, 12'h0F0, 2);
      draw_line(5, 5, 7, 5, 12'hF0F, 3);

      // Random lines: mostly short, some medium, a few spanning the screen. Some are
      // cut short by the next start, some run on into steps with no line.
      next_pause = PAUSE_EVERY;
      while (items_sent < ITEM_TARGET) begin
         kind   = $urandom_range(0, 99);
         steady <= ($urandom_range(0, 6) == 0);
         if (kind < 5) begin
            send_step();
         end else begin
            reach = (kind < 7) ? X_MAX + 1 : (kind < 22) ? 80 : 12;
            x0 = $urandom_range(0, X_MAX);
            y0 = $urandom_range(0, Y_MAX);
            x1 = clamp(x0 + int'($urandom_range(0, 2 * reach)) - reach, X_MAX);
            y1 = clamp(y0 + int'($urandom_range(0, 2 * reach)) - reach, Y_MAX);
            steps = ((x1 > x0 ? x1 - x0 : x0 - x1) > (y1 > y0 ? y1 - y0 : y0 - y1))
                    ? (x1 > x0 ? x1 - x0 : x0 - x1) + 1
                    : (y1 > y0 ? y1 - y0 : y0 - y1) + 1;
            fate = $urandom_range(0, 9);
            if (fate == 0) steps = int'($urandom_range(0, steps - 1));
            else if (fate == 1) steps += int'($urandom_range(1, 3));
            draw_line(x0, y0, x1, y1, int'($urandom_range(0, 4095)), steps);
         end
         if (items_sent >= next_pause) begin
            drain_pixels();
            next_pause += PAUSE_EVERY;
         end
      end

      // Let everything in flight arrive, then watch for stray pixels.
      steady <= 1'b1;
      drain_pixels();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d request transactions: %0d lines started, %0d pixels checked.",
               items_sent, lines_started, pixels_checked);
      $display("Lines covered corner points, both axis orders, abandoned lines and idle steps.");
      if (fail_count == 0 && pending_pixels == 0) begin
         $display("** line_pixel_generator_core: PASSED **");
      end else begin
         $display("** line_pixel_generator_core: FAILED **");
      end
      $finish;
   end

endmodule
